[sv/chd_pkg.sv]
`default_nettype none

package chd_pkg;

	// width of the chunk size accumulator
	localparam int unsigned SIZE_BITS = 32;

	// error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_SIZE   = 2'd1;
	localparam logic [1:0] ERR_FRAME  = 2'd2;

	// one result beat
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       chunk_done;
		logic       body_done;
		logic [1:0] error_code;
	} result_t;

endpackage

`default_nettype wire

[sv/chd_parser.sv]
`default_nettype none

module chd_parser import chd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] body_byte,
	input  wire logic       start_message,
	output result_t         result
);

	localparam logic [3:0] PH_DIGITS  = 4'd0;
	localparam logic [3:0] PH_SKIP    = 4'd1;
	localparam logic [3:0] PH_SIZE_LF = 4'd2;
	localparam logic [3:0] PH_DATA    = 4'd3;
	localparam logic [3:0] PH_DATA_CR = 4'd4;
	localparam logic [3:0] PH_DATA_LF = 4'd5;
	localparam logic [3:0] PH_LAST_CR = 4'd6;
	localparam logic [3:0] PH_LAST_LF = 4'd7;
	localparam logic [3:0] PH_DONE    = 4'd8;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	logic [3:0]           phase_q,  phase_d,  phase_c;
	logic [SIZE_BITS-1:0] length_q, length_d, length_c;
	logic [SIZE_BITS-1:0] left_q,   left_d,   left_c, left_dec;
	logic                 seen_q,   seen_d,   seen_c;
	logic [1:0]           err_q,    err_d,    err_c,  err_new;
	logic                 is_hex;
	logic [3:0]           hex_val;
	logic                 pv, cdone, bdone;

	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (body_byte inside {[8'h30:8'h39]}) begin
			hex_val = body_byte[3:0];
		end else if (body_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			hex_val = 4'(body_byte[2:0] + 3'd1) + 4'd8;
		end else begin
			is_hex = 1'b0;
		end
	end

	// start_message restarts the state ahead of this byte
	always_comb begin
		if (start_message) begin
			phase_c  = PH_DIGITS;
			length_c = '0;
			left_c   = '0;
			seen_c   = 1'b0;
			err_c    = ERR_NONE;
		end else begin
			phase_c  = phase_q;
			length_c = length_q;
			left_c   = left_q;
			seen_c   = seen_q;
			err_c    = err_q;
		end
	end

	assign left_dec = (left_c != '0) ? left_c - 1'b1 : left_c;

	always_comb begin
		phase_d  = phase_c;
		length_d = length_c;
		left_d   = left_c;
		seen_d   = seen_c;
		err_new  = ERR_NONE;
		pv       = 1'b0;
		cdone    = 1'b0;
		bdone    = 1'b0;
		if (err_c == ERR_NONE) begin
			case (phase_c)
				PH_DIGITS: begin
					if (body_byte == CH_CR) begin
						phase_d = PH_SIZE_LF;
					end else if (body_byte == CH_LF) begin
						err_new = ERR_FRAME;
					end else if (is_hex) begin
						if (length_c[SIZE_BITS-1 -: 4] != 4'd0) begin
							err_new = ERR_SIZE;
						end else begin
							length_d = {length_c[SIZE_BITS-5:0], hex_val};
							seen_d   = 1'b1;
						end
					end else begin
						phase_d = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (body_byte == CH_CR) begin
						phase_d = PH_SIZE_LF;
					end else if (body_byte == CH_LF) begin
						err_new = ERR_FRAME;
					end
				end
				PH_SIZE_LF: begin
					if (body_byte != CH_LF) begin
						err_new = ERR_FRAME;
					end else if (!seen_c) begin
						err_new = ERR_SIZE;
					end else if (length_c == '0) begin
						phase_d = PH_LAST_CR;
					end else begin
						left_d  = length_c;
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					pv     = 1'b1;
					left_d = left_dec;
					if (left_dec == '0) begin
						phase_d = PH_DATA_CR;
					end
				end
				PH_DATA_CR: begin
					if (body_byte == CH_CR) phase_d = PH_DATA_LF;
					else err_new = ERR_FRAME;
				end
				PH_DATA_LF: begin
					if (body_byte == CH_LF) begin
						cdone    = 1'b1;
						phase_d  = PH_DIGITS;
						length_d = '0;
						seen_d   = 1'b0;
					end else begin
						err_new = ERR_FRAME;
					end
				end
				PH_LAST_CR: begin
					if (body_byte == CH_CR) phase_d = PH_LAST_LF;
					else err_new = ERR_FRAME;
				end
				PH_LAST_LF: begin
					if (body_byte == CH_LF) begin
						bdone   = 1'b1;
						phase_d = PH_DONE;
					end else begin
						err_new = ERR_FRAME;
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
		err_d = (err_new != ERR_NONE) ? err_new : err_c;
	end

	always_comb begin
		result = '0;
		result.error_code = err_d;
		if (err_d == ERR_NONE) begin
			result.payload_valid = pv;
			result.payload_byte  = pv ? body_byte : 8'd0;
			result.chunk_done    = cdone;
			result.body_done     = bdone;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DIGITS;
			length_q <= '0;
			left_q   <= '0;
			seen_q   <= 1'b0;
			err_q    <= ERR_NONE;
		end else if (step) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			left_q   <= left_d;
			seen_q   <= seen_d;
			err_q    <= err_d;
		end
	end

endmodule

`default_nettype wire

[sv/chd_out_queue.sv]
`default_nettype none

module chd_out_queue import chd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         can_push,
	input  wire logic    pop_stall,
	output logic         head_valid,
	output result_t      head_data
);

	// two slots: head drives the port, second one is the skid
	result_t    slot0_q, slot1_q;
	logic [1:0] count_q;
	logic       pop;

	assign head_valid = (count_q != 2'd0);
	assign head_data  = slot0_q;
	assign pop        = head_valid && !pop_stall;
	assign can_push   = (count_q != 2'd2) || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= 2'(count_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) slot0_q <= push_data;
				else slot1_q <= push_data;
			end
			2'b01: begin
				slot0_q <= slot1_q;
			end
			2'b11: begin
				if (count_q == 2'd1) begin
					slot0_q <= push_data;
				end else begin
					slot0_q <= slot1_q;
					slot1_q <= push_data;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/http_chunked_body_deframer.sv]
`default_nettype none

// HTTP/1.1 chunked body deframer. One body byte goes in per beat and exactly
// one result beat comes out for it, in order: the byte itself when it is
// chunk payload (payload_valid), a pulse on chunk_done at the LF that closes a
// chunk's data, a pulse on body_done at the LF of the empty line after the
// zero size chunk, and error_code (1 bad or overflowing size, 2 bad framing).
// An error holds until a beat with start_message set, which restarts the
// parser at a size line before its own byte. Bytes after body end give all
// zero results. Throughput is one byte per clock, sustained while the output
// is not stalled: the parser is a single pass of logic between the input
// register and a two-slot result queue, and its state updates once per byte.
// A byte is registered at the input and its result in the queue; the second
// queue slot takes one more result under output stall, then in_stall rises.

module http_chunked_body_deframer import chd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] body_byte,
	input  wire logic       start_message,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      payload_byte,
	output logic            payload_valid,
	output logic            chunk_done,
	output logic            body_done,
	output logic [1:0]      error_code
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       advance;
	logic       can_push;
	result_t    result;
	result_t    head;

	// input beat register; it moves on once the queue has room
	assign advance  = valid_s1 && can_push;
	assign in_stall = valid_s1 && !can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= body_byte;
			start_s1 <= start_message;
		end
	end

	// framing state machine, stepped once per byte leaving the input register
	chd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.body_byte     (byte_s1),
		.start_message (start_s1),
		.result        (result)
	);

	// result register plus skid slot
	chd_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (advance),
		.push_data  (result),
		.can_push   (can_push),
		.pop_stall  (out_stall),
		.head_valid (out_valid),
		.head_data  (head)
	);

	assign payload_byte  = head.payload_byte;
	assign payload_valid = head.payload_valid;
	assign chunk_done    = head.chunk_done;
	assign body_done     = head.body_done;
	assign error_code    = head.error_code;

endmodule

`default_nettype wire

[sv/chd_checker.sv]
`default_nettype none

module chd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] payload_byte,
	input wire logic       payload_valid,
	input wire logic       chunk_done,
	input wire logic       body_done,
	input wire logic [1:0] error_code
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte)
			&& $stable(payload_valid) && $stable(chunk_done)
			&& $stable(body_done) && $stable(error_code))
		else $error("result beat changed under stall");

	// an error masks every other flag
	a_err_masks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != 2'd0 |->
			!payload_valid && !chunk_done && !body_done)
		else $error("flags set alongside an error");

	// a byte is payload, a chunk end or a body end, never two
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({payload_valid, chunk_done, body_done}))
		else $error("more than one event in a beat");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code != 2'd3)
		else $error("unknown error code");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == 8'd0)
		else $error("payload byte set on a non-payload beat");

endmodule

bind http_chunked_body_deframer chd_checker u_chk (.*);

`default_nettype wire
